/* src/bss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants for the boot slot selector
// Register indexes, reset values, tier codes and the structs passed between
// the register file, the slot checker and the tier trackers.
// ----------------------------------------------------------------------------
package bss_pkg;

	typedef logic [31:0] word_t;

	localparam int MAX_SLOTS_DEF = 2;
	localparam int NUM_TIERS     = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int IN_DATA_W     = 232;
	localparam int OUT_DATA_W    = 40;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_FAIL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_A_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_A_END    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_B_START  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_B_END    = 3'd6;

	// Register reset values
	localparam word_t RST_MAX_ATTEMPTS = 32'd3;
	localparam word_t RST_FORCE_FAIL   = 32'hFFFF_FFFF;
	localparam word_t RST_SLOT_SIZE    = 32'd0;
	localparam word_t RST_RAM_A_START  = 32'h2000_0000;
	localparam word_t RST_RAM_A_END    = 32'h2002_0000;
	localparam word_t RST_RAM_B_START  = 32'h2400_0000;
	localparam word_t RST_RAM_B_END    = 32'h2405_0000;

	// Tier codes
	localparam logic [1:0] TIER_NORMAL   = 2'd0;
	localparam logic [1:0] TIER_NO_LIMIT = 2'd1;
	localparam logic [1:0] TIER_ANY      = 2'd2;

	typedef struct packed {
		word_t max_attempts;
		word_t force_fail_marker;
		word_t slot_size;
		word_t ram_a_start;
		word_t ram_a_end;
		word_t ram_b_start;
		word_t ram_b_end;
	} cfg_t;

	typedef struct packed {
		logic  image_check_ok;
		word_t stack_word;
		word_t entry_word;
		word_t code_base;
		word_t slot_base;
		logic  has_record;
		word_t boot_tries;
		logic  confirmed;
		word_t inst_seq;
		word_t image_version;
		logic  last_slot;
	} slot_in_t;

	// Classified slot: one offer bit per tier
	typedef struct packed {
		logic [NUM_TIERS-1:0] offer;
		word_t                seq;
		word_t                ver;
		word_t                cnt;
		logic                 conf;
		logic                 last;
	} slot_item_t;

	typedef struct packed {
		logic       found;
		logic       slot;
		logic [1:0] tier;
		logic       bump;
		word_t      new_count;
	} result_t;

endpackage

/* src/bss_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_cfg: configuration register file
// Seven 32-bit registers written through a plain write port, no read-back.
// ----------------------------------------------------------------------------
module bss_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [bss_pkg::CFG_IDX_W-1:0]  addr,
	input  bss_pkg::word_t                 wdata,
	output bss_pkg::cfg_t                  cfg
);
	import bss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_attempts      <= RST_MAX_ATTEMPTS;
			cfg_q.force_fail_marker <= RST_FORCE_FAIL;
			cfg_q.slot_size         <= RST_SLOT_SIZE;
			cfg_q.ram_a_start       <= RST_RAM_A_START;
			cfg_q.ram_a_end         <= RST_RAM_A_END;
			cfg_q.ram_b_start       <= RST_RAM_B_START;
			cfg_q.ram_b_end         <= RST_RAM_B_END;
		end else if (we) begin
			unique case (addr)
				CFG_MAX_ATTEMPTS: cfg_q.max_attempts      <= wdata;
				CFG_FORCE_FAIL:   cfg_q.force_fail_marker <= wdata;
				CFG_SLOT_SIZE:    cfg_q.slot_size         <= wdata;
				CFG_RAM_A_START:  cfg_q.ram_a_start       <= wdata;
				CFG_RAM_A_END:    cfg_q.ram_a_end         <= wdata;
				CFG_RAM_B_START:  cfg_q.ram_b_start       <= wdata;
				CFG_RAM_B_END:    cfg_q.ram_b_end         <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/bss_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_check: slot record input register and validity check
// Registers the incoming record, checks stack and entry words against the
// windows and decides which tiers the slot may enter.
// ----------------------------------------------------------------------------
module bss_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bss_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bss_pkg::slot_in_t    in_item,
	output logic                 valid_s2,
	output bss_pkg::slot_item_t  item_s2,
	input  logic                 take
);
	import bss_pkg::*;

	logic       valid_s1;
	slot_in_t   rec_s1;
	slot_item_t cls;
	logic       s2_free;
	logic       s1_go;
	word_t      addr;
	word_t      hi;
	word_t      cnt;
	logic       conf;
	logic       sp_ok;
	logic       ep_ok;
	logic       slot_ok;
	logic       rejected;
	logic       exhausted;

	assign s2_free  = !valid_s2 || take;
	assign s1_go    = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_comb begin
		addr = {rec_s1.entry_word[31:1], 1'b0};
		hi   = rec_s1.slot_base + cfg.slot_size;
		cnt  = rec_s1.has_record ? rec_s1.boot_tries : '0;
		conf = rec_s1.has_record && rec_s1.confirmed;

		sp_ok = (rec_s1.stack_word[1:0] == 2'b00) &&
			((rec_s1.stack_word > cfg.ram_a_start && rec_s1.stack_word <= cfg.ram_a_end) ||
			 (rec_s1.stack_word > cfg.ram_b_start && rec_s1.stack_word <= cfg.ram_b_end));
		ep_ok = rec_s1.entry_word[0] && (addr >= rec_s1.code_base) && (addr < hi);
		slot_ok = rec_s1.image_check_ok && sp_ok && ep_ok;

		rejected  = rec_s1.has_record && (cnt == cfg.force_fail_marker);
		exhausted = rec_s1.has_record && !conf && (cnt >= cfg.max_attempts);

		cls.offer[TIER_NORMAL]   = slot_ok && !rejected && !exhausted;
		cls.offer[TIER_NO_LIMIT] = slot_ok && !rejected;
		cls.offer[TIER_ANY]      = slot_ok;
		cls.seq  = rec_s1.inst_seq;
		cls.ver  = rec_s1.image_version;
		cls.cnt  = cnt;
		cls.conf = conf;
		cls.last = rec_s1.last_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				valid_s2 <= 1'b1;
			end else if (take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rec_s1 <= in_item;
		end
		if (s1_go) begin
			item_s2 <= cls;
		end
	end

endmodule

/* src/bss_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_track: per-tier best slot trackers and result register
// Keeps the newest slot of each tier over one scan and, on the last record,
// picks the lowest tier that holds a slot and registers the result.
// ----------------------------------------------------------------------------
module bss_track #(
	parameter int MAX_SLOTS = bss_pkg::MAX_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bss_pkg::cfg_t        cfg,
	input  logic                 valid_s2,
	input  bss_pkg::slot_item_t  item_s2,
	output logic                 take,
	output logic                 res_valid,
	input  logic                 res_ready,
	output bss_pkg::result_t     res
);
	import bss_pkg::*;

	localparam int               CNT_W   = $clog2(MAX_SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SLOTS);

	logic [CNT_W-1:0]     slot_cnt_q;
	logic [NUM_TIERS-1:0] found_q;
	logic [NUM_TIERS-1:0] idx_q;
	logic [NUM_TIERS-1:0] conf_q;
	word_t                seq_q [NUM_TIERS];
	word_t                ver_q [NUM_TIERS];
	word_t                cnt_q [NUM_TIERS];

	logic [NUM_TIERS-1:0] found_nxt;
	logic [NUM_TIERS-1:0] idx_nxt;
	logic [NUM_TIERS-1:0] conf_nxt;
	word_t                seq_nxt [NUM_TIERS];
	word_t                ver_nxt [NUM_TIERS];
	word_t                cnt_nxt [NUM_TIERS];
	logic [NUM_TIERS-1:0] newer;

	logic                 in_range;
	logic [1:0]           pick;
	result_t              pick_res;
	logic                 res_valid_q;
	result_t              res_q;

	assign take     = valid_s2 && (!item_s2.last || !res_valid_q || res_ready);
	assign in_range = slot_cnt_q < CNT_MAX;

	// Offer the slot to each tier; an equal age keeps the earlier slot
	always_comb begin
		for (int t = 0; t < NUM_TIERS; t++) begin
			newer[t] = !found_q[t] || (item_s2.seq > seq_q[t]) ||
				((item_s2.seq == seq_q[t]) && (item_s2.ver > ver_q[t]));
			found_nxt[t] = found_q[t];
			idx_nxt[t]   = idx_q[t];
			conf_nxt[t]  = conf_q[t];
			seq_nxt[t]   = seq_q[t];
			ver_nxt[t]   = ver_q[t];
			cnt_nxt[t]   = cnt_q[t];
			if (in_range && item_s2.offer[t] && newer[t]) begin
				found_nxt[t] = 1'b1;
				idx_nxt[t]   = slot_cnt_q[0];
				conf_nxt[t]  = item_s2.conf;
				seq_nxt[t]   = item_s2.seq;
				ver_nxt[t]   = item_s2.ver;
				cnt_nxt[t]   = item_s2.cnt;
			end
		end
	end

	// Lowest tier holding a slot wins
	always_comb begin
		if (found_nxt[TIER_NORMAL]) begin
			pick = TIER_NORMAL;
		end else if (found_nxt[TIER_NO_LIMIT]) begin
			pick = TIER_NO_LIMIT;
		end else begin
			pick = TIER_ANY;
		end
		pick_res = '0;
		if (|found_nxt) begin
			pick_res.found     = 1'b1;
			pick_res.slot      = idx_nxt[pick];
			pick_res.tier      = pick;
			pick_res.bump      = !conf_nxt[pick] && (cnt_nxt[pick] != cfg.force_fail_marker);
			pick_res.new_count = cnt_nxt[pick] + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q  <= '0;
			found_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (item_s2.last) begin
					slot_cnt_q <= '0;
					found_q    <= '0;
				end else begin
					found_q <= found_nxt;
					if (in_range) begin
						slot_cnt_q <= slot_cnt_q + 1'b1;
					end
				end
			end
			if (take && item_s2.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q  <= idx_nxt;
			conf_q <= conf_nxt;
			for (int t = 0; t < NUM_TIERS; t++) begin
				seq_q[t] <= seq_nxt[t];
				ver_q[t] <= ver_nxt[t];
				cnt_q[t] <= cnt_nxt[t];
			end
		end
		if (take && item_s2.last) begin
			res_q <= pick_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_scan_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s2.last |=> slot_cnt_q == '0 && found_q == '0)
		else $error("scan state not cleared after last record");

	a_tier_nesting: assert property (@(posedge clk) disable iff (!arst_n)
		(!found_q[TIER_NORMAL] || found_q[TIER_NO_LIMIT]) &&
		(!found_q[TIER_NO_LIMIT] || found_q[TIER_ANY]))
		else $error("tier trackers out of order");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_cnt_q <= CNT_MAX)
		else $error("slot counter past limit");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.found |->
		res_q.tier == TIER_NORMAL && !res_q.bump && !res_q.slot && res_q.new_count == '0)
		else $error("empty result carries data");

endmodule

/* src/boot_slot_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_slot_selector: A/B boot slot selection with attempt limit and rollback
// Checks one slot record per item, tracks the newest slot per tier and gives
// the chosen slot with its boot count update on the last record.
// ----------------------------------------------------------------------------
// Throughput: one slot record per cycle, set by the single tracker update per
// cycle in bss_track; a waiting result stalls only a following last record.
// Path: the result of a last record passes the input register, the check
// register and the result register before it shows on m_tvalid.
// Reset: arst_n clears all valids, the scan and the registers to their
// default values; no clearing pass.
module boot_slot_selector #(
	parameter int MAX_SLOTS = bss_pkg::MAX_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// image_check_ok[0], stack_word[32:1], entry_word[64:33], code_base[96:65],
	// slot_base[128:97], has_record[129], boot_tries[161:130], confirmed[162],
	// inst_seq[194:163], image_version[226:195], zero fill [231:227]
	input  logic [bss_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// found[0], chosen_slot[1], chosen_tier[3:2], bump_count[4],
	// new_count[36:5], zero fill [39:37]
	output logic [bss_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            cfg_we,
	input  logic [bss_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  bss_pkg::word_t                  cfg_wdata
);
	import bss_pkg::*;

	cfg_t       cfg;
	slot_in_t   in_item;
	logic       valid_s2;
	slot_item_t item_s2;
	logic       take;
	result_t    res;

	always_comb begin
		in_item.image_check_ok = s_tdata[0];
		in_item.stack_word     = s_tdata[32:1];
		in_item.entry_word     = s_tdata[64:33];
		in_item.code_base      = s_tdata[96:65];
		in_item.slot_base      = s_tdata[128:97];
		in_item.has_record     = s_tdata[129];
		in_item.boot_tries     = s_tdata[161:130];
		in_item.confirmed      = s_tdata[162];
		in_item.inst_seq       = s_tdata[194:163];
		in_item.image_version  = s_tdata[226:195];
		in_item.last_slot      = s_tlast;
	end

	bss_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	bss_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.take     (take)
	);

	bss_track #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.item_s2   (item_s2),
		.take      (take),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {3'b000, res.new_count, res.bump, res.tier, res.slot, res.found};

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the boot slot selector
// Streams slot records into the selector and predicts each scan's choice
// with an in-bench tracker model. Runs directed checks of slot validity and
// tier ranking, then random scans under several register settings, with
// random gaps on the input side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

	import bss_pkg::*;

	localparam int    SLOT_LIMIT = MAX_SLOTS_DEF;
	localparam word_t BASE_A     = 32'h0802_0000;
	localparam word_t BASE_B     = 32'h0806_0000;
	localparam cfg_t  CFG_RESET  = '{RST_MAX_ATTEMPTS, RST_FORCE_FAIL, RST_SLOT_SIZE,
		RST_RAM_A_START, RST_RAM_A_END, RST_RAM_B_START, RST_RAM_B_END};
	localparam cfg_t  CFG_TYPICAL = '{32'd3, 32'hFFFF_FFFF, 32'h0004_0000,
		RST_RAM_A_START, RST_RAM_A_END, RST_RAM_B_START, RST_RAM_B_END};

	typedef struct {
		bit    found;
		bit    idx;
		word_t seq;
		word_t ver;
		word_t cnt;
		bit    conf;
	} best_slot_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
	word_t                 cfg_wdata = '0;

	// Bench copy of the registers and the per-tier newest slot
	cfg_t       cfg_shadow;
	best_slot_t best [3];
	int         scan_pos;
	result_t    expected_choices [$];

	bit idling      = 1'b1;
	int ready_hold  = 0;
	int fault_count = 0;

	boot_slot_selector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		if (!idling)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_scan();
		scan_pos = 0;
		for (int t = 0; t < 3; t++)
			best[t] = '{1'b0, 1'b0, '0, '0, '0, 1'b0};
	endfunction

	function automatic void offer_tier(input logic [1:0] t, input bit idx,
		input word_t seq, ver, cnt, input bit conf);
		if (!best[t].found || seq > best[t].seq || (seq == best[t].seq && ver > best[t].ver))
			best[t] = '{1'b1, idx, seq, ver, cnt, conf};
	endfunction

	// Classify one slot record, update the tier trackers and queue the choice
	// when the record closes the scan
	function automatic void track_slot(input slot_in_t r);
		word_t      cnt, addr, hi, sp;
		bit         conf, sp_ok, ep_ok, rejected, exhausted, have;
		logic [1:0] pick;
		result_t    res;
		cnt  = r.has_record ? r.boot_tries : '0;
		conf = r.has_record && r.confirmed;
		sp   = r.stack_word;
		if (scan_pos < SLOT_LIMIT) begin
			addr  = {r.entry_word[31:1], 1'b0};
			hi    = r.slot_base + cfg_shadow.slot_size;
			sp_ok = (sp[1:0] == 2'b00) &&
				((sp > cfg_shadow.ram_a_start && sp <= cfg_shadow.ram_a_end) ||
				 (sp > cfg_shadow.ram_b_start && sp <= cfg_shadow.ram_b_end));
			ep_ok = r.entry_word[0] && addr >= r.code_base && addr < hi;
			rejected  = r.has_record && cnt == cfg_shadow.force_fail_marker;
			exhausted = r.has_record && !conf && cnt >= cfg_shadow.max_attempts;
			if (r.image_check_ok && sp_ok && ep_ok) begin
				if (!rejected && !exhausted)
					offer_tier(TIER_NORMAL, scan_pos[0], r.inst_seq, r.image_version,
						cnt, conf);
				if (!rejected)
					offer_tier(TIER_NO_LIMIT, scan_pos[0], r.inst_seq, r.image_version,
						cnt, conf);
				offer_tier(TIER_ANY, scan_pos[0], r.inst_seq, r.image_version, cnt, conf);
			end
			scan_pos++;
		end
		if (r.last_slot) begin
			res  = '0;
			have = 1'b1;
			if (best[TIER_NORMAL].found)
				pick = TIER_NORMAL;
			else if (best[TIER_NO_LIMIT].found)
				pick = TIER_NO_LIMIT;
			else if (best[TIER_ANY].found)
				pick = TIER_ANY;
			else
				have = 1'b0;
			if (have) begin
				res.found     = 1'b1;
				res.slot      = best[pick].idx;
				res.tier      = pick;
				res.bump      = !best[pick].conf &&
					best[pick].cnt != cfg_shadow.force_fail_marker;
				res.new_count = best[pick].cnt + 32'd1;
			end
			expected_choices.push_back(res);
			clear_scan();
		end
	endfunction

	task automatic send_slot(input slot_in_t r);
		int gap;
		s_tdata  <= {5'b0, r.image_version, r.inst_seq, r.confirmed, r.boot_tries,
			r.has_record, r.slot_base, r.code_base, r.entry_word, r.stack_word,
			r.image_check_ok};
		s_tlast  <= r.last_slot;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		track_slot(r);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, drain every pending choice, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_choices.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		logic [CFG_IDX_W-1:0] idx [7];
		word_t                vals [7];
		wait_idle();
		idx  = '{CFG_MAX_ATTEMPTS, CFG_FORCE_FAIL, CFG_SLOT_SIZE, CFG_RAM_A_START,
			CFG_RAM_A_END, CFG_RAM_B_START, CFG_RAM_B_END};
		vals = '{c.max_attempts, c.force_fail_marker, c.slot_size, c.ram_a_start,
			c.ram_a_end, c.ram_b_start, c.ram_b_end};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we     <= 1'b0;
		cfg_shadow = c;
	endtask

	// A slot that passes every check under the typical settings
	function automatic slot_in_t good_slot(input word_t base, input word_t seq, ver, cnt,
		input bit conf, last);
		slot_in_t r;
		r.image_check_ok = 1'b1;
		r.stack_word     = 32'h2001_FF00;
		r.entry_word     = base + 32'h4C1;
		r.code_base      = base + 32'h400;
		r.slot_base      = base;
		r.has_record     = 1'b1;
		r.boot_tries     = cnt;
		r.confirmed      = conf;
		r.inst_seq       = seq;
		r.image_version  = ver;
		r.last_slot      = last;
		return r;
	endfunction

	function automatic word_t pick_stack();
		word_t lo, hi, sp;
		if ($urandom_range(0, 1)) begin
			lo = cfg_shadow.ram_a_start;
			hi = cfg_shadow.ram_a_end;
		end else begin
			lo = cfg_shadow.ram_b_start;
			hi = cfg_shadow.ram_b_end;
		end
		case ($urandom_range(0, 11))
			0: sp = lo;
			1: sp = hi;
			2: sp = hi + 32'd4;
			3: sp = lo + 32'd4;
			4: sp = $urandom;
			5: sp = hi | 32'd2;
			default: begin
				sp = (hi > lo) ? lo + 32'd1 + ($urandom % (hi - lo)) : $urandom;
				sp = {sp[31:2], 2'b00};
			end
		endcase
		return sp;
	endfunction

	function automatic word_t pick_count();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return cfg_shadow.max_attempts - 32'd1;
			2: return cfg_shadow.max_attempts;
			3: return cfg_shadow.max_attempts + 32'd1;
			4: return cfg_shadow.force_fail_marker;
			5: return $urandom_range(0, 5);
			6: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Small values most of the time so that equal ages turn up
	function automatic word_t pick_age();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic slot_in_t shaped_slot(input bit last);
		slot_in_t r;
		word_t    hi, addr;
		r.image_check_ok = ($urandom_range(0, 19) != 0);
		r.stack_word     = pick_stack();
		r.slot_base      = $urandom;
		r.code_base      = r.slot_base + $urandom_range(0, 'h800) - 32'h400;
		hi               = r.slot_base + cfg_shadow.slot_size;
		case ($urandom_range(0, 9))
			0: addr = r.code_base;
			1: addr = hi - 32'd2;
			2: addr = hi;
			3: addr = r.code_base - 32'd2;
			4: addr = $urandom;
			default: addr = (hi > r.code_base) ?
				r.code_base + ($urandom % (hi - r.code_base)) : $urandom;
		endcase
		r.entry_word    = {addr[31:1], ($urandom_range(0, 19) != 0)};
		r.has_record    = ($urandom_range(0, 4) != 0);
		r.boot_tries    = pick_count();
		r.confirmed     = 1'($urandom);
		r.inst_seq      = pick_age();
		r.image_version = pick_age();
		r.last_slot     = last;
		return r;
	endfunction

	function automatic slot_in_t noise_slot();
		slot_in_t r;
		r.image_check_ok = 1'($urandom);
		r.stack_word     = $urandom;
		r.entry_word     = $urandom;
		r.code_base      = $urandom;
		r.slot_base      = $urandom;
		r.has_record     = 1'($urandom);
		r.boot_tries     = $urandom;
		r.confirmed      = 1'($urandom);
		r.inst_seq       = $urandom;
		r.image_version  = $urandom;
		r.last_slot      = ($urandom_range(0, 2) == 0);
		return r;
	endfunction

	task automatic check_choice();
		result_t got, want;
		got.found     = m_tdata[0];
		got.slot      = m_tdata[1];
		got.tier      = m_tdata[3:2];
		got.bump      = m_tdata[4];
		got.new_count = m_tdata[36:5];
		if (expected_choices.size() == 0) begin
			fault_count++;
			if (fault_count <= 10)
				$display("tb: result with nothing pending: %h", m_tdata);
		end else begin
			want = expected_choices.pop_front();
			if (got.found !== want.found || got.slot !== want.slot || got.tier !== want.tier ||
				got.bump !== want.bump || got.new_count !== want.new_count) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("tb: mismatch: expected found=%0b slot=%0b tier=%0d bump=%0b count=%h",
						want.found, want.slot, want.tier, want.bump, want.new_count);
					$display("tb:           got      found=%0b slot=%0b tier=%0d bump=%0b count=%h",
						got.found, got.slot, got.tier, got.bump, got.new_count);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_choice();
	end

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold = ready_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	// Registers still at reset: zero slot size puts the entry bound at the slot base
	task automatic test_reset_defaults();
		slot_in_t r;
		r = good_slot(BASE_A, 32'd1, 32'd1, 32'd0, 1'b0, 1'b1);
		r.slot_base  = BASE_A + 32'h2_0000;
		r.stack_word = RST_RAM_B_END;
		send_slot(r);
		r.stack_word = RST_RAM_B_END + 32'd4;
		send_slot(r);
	endtask

	task automatic test_slot_checks();
		slot_in_t r;
		load_config(CFG_TYPICAL);
		r = good_slot(BASE_A, 32'd1, 32'd1, 32'd0, 1'b0, 1'b1);
		r.stack_word = RST_RAM_A_END;
		send_slot(r);
		r.stack_word = RST_RAM_A_START;
		send_slot(r);
		r.stack_word = 32'h2001_FF02;
		send_slot(r);
		r = good_slot(BASE_A, 32'd1, 32'd1, 32'd0, 1'b0, 1'b1);
		r.entry_word[0] = 1'b0;
		send_slot(r);
		r.entry_word = BASE_A + 32'h4_0001;
		send_slot(r);
		r.entry_word = BASE_A + 32'h3_FFFF;
		send_slot(r);
		r.entry_word = BASE_A + 32'h3FF;
		send_slot(r);
		r = good_slot(BASE_A, 32'd1, 32'd1, 32'd0, 1'b0, 1'b1);
		r.image_check_ok = 1'b0;
		send_slot(r);
		r.image_check_ok = 1'b1;
		r.stack_word     = RST_RAM_B_START + 32'd4;
		send_slot(r);
	endtask

	task automatic test_tier_choice();
		slot_in_t r;
		// newer sequence wins
		send_slot(good_slot(BASE_A, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0));
		send_slot(good_slot(BASE_B, 32'd2, 32'd0, 32'd0, 1'b0, 1'b1));
		// version breaks a sequence tie
		send_slot(good_slot(BASE_A, 32'd2, 32'd5, 32'd0, 1'b0, 1'b0));
		send_slot(good_slot(BASE_B, 32'd2, 32'd4, 32'd1, 1'b0, 1'b1));
		// equal age keeps the earlier slot
		send_slot(good_slot(BASE_A, 32'd7, 32'd7, 32'd0, 1'b0, 1'b0));
		send_slot(good_slot(BASE_B, 32'd7, 32'd7, 32'd2, 1'b0, 1'b1));
		// exhausted newer slot falls back to the confirmed older one
		send_slot(good_slot(BASE_A, 32'd1, 32'd0, 32'd0, 1'b1, 1'b0));
		send_slot(good_slot(BASE_B, 32'd2, 32'd0, 32'd3, 1'b0, 1'b1));
		// both exhausted: attempt limit ignored
		send_slot(good_slot(BASE_A, 32'd1, 32'd0, 32'd5, 1'b0, 1'b0));
		send_slot(good_slot(BASE_B, 32'd2, 32'd0, 32'd3, 1'b0, 1'b1));
		// both rejected: rollback ignored, count wraps, no bump
		send_slot(good_slot(BASE_A, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0));
		send_slot(good_slot(BASE_B, 32'd2, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1));
		// missing boot record reads as count zero, unconfirmed
		send_slot(good_slot(BASE_A, 32'd3, 32'd0, 32'd9, 1'b0, 1'b0));
		r = good_slot(BASE_B, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
		r.has_record = 1'b0;
		send_slot(r);
		// records past the slot limit are ignored
		send_slot(good_slot(BASE_A, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0));
		send_slot(good_slot(BASE_B, 32'd2, 32'd0, 32'd0, 1'b0, 1'b0));
		send_slot(good_slot(BASE_A, 32'd9, 32'd0, 32'd0, 1'b0, 1'b1));
	endtask

	// Mostly well-formed scans with random content, some stray records between
	task automatic test_random_scans(input cfg_t c, input bit with_gaps, input int n);
		int sent, len, k;
		load_config(c);
		idling = with_gaps;
		sent   = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				send_slot(noise_slot());
				sent++;
			end else begin
				k   = $urandom_range(0, 19);
				len = (k < 3) ? 1 : (k < 17) ? 2 : $urandom_range(3, 4);
				for (int j = 0; j < len; j++) begin
					send_slot(shaped_slot(j == len - 1));
					sent++;
				end
			end
		end
		wait_idle();
		idling = 1'b1;
	endtask

	initial begin
		cfg_t mixed;
		cfg_shadow = CFG_RESET;
		clear_scan();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_slot_checks();
		test_tier_choice();
		test_random_scans(CFG_TYPICAL, 1'b1, 300);
		test_random_scans(CFG_RESET, 1'b0, 200);
		test_random_scans('{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd0}, 1'b1, 200);
		test_random_scans('{32'hFFFF_FFFF, 32'd3, 32'h0000_1000, 32'h2000_0000,
			32'h2000_0004, 32'hFFFF_FFFB, 32'hFFFF_FFFF}, 1'b1, 200);
		mixed.max_attempts      = $urandom_range(0, 6);
		mixed.force_fail_marker = $urandom_range(0, 8);
		mixed.slot_size         = $urandom_range(1, 'h10_0000);
		mixed.ram_a_start       = $urandom;
		mixed.ram_a_end         = mixed.ram_a_start + $urandom_range(0, 'h4_0000);
		mixed.ram_b_start       = $urandom;
		mixed.ram_b_end         = mixed.ram_b_start + $urandom_range(0, 'h4_0000);
		test_random_scans(mixed, 1'b1, 300);
		wait_idle();
		if (fault_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
src/bss_pkg.sv
src/bss_cfg.sv
src/bss_check.sv
src/bss_track.sv
src/boot_slot_selector.sv
dv/tb.sv
